[rtl/stack_machine_execute_core_assert.svh]
// Assertion macros shared by the stack machine execute core.
`ifndef STACK_MACHINE_EXECUTE_CORE_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMX_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("smx assertion failed");

// Next-cycle implication, checked outside reset.
`define SMX_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("smx assertion failed");

`endif

[rtl/smx_pkg.sv]
// Package with opcodes and status codes of the stack machine execute core.
`timescale 1ns / 1ps
package smx_pkg;
  localparam logic [4:0] OP_PUSH  = 5'd5;
  localparam logic [4:0] OP_POP   = 5'd6;
  localparam logic [4:0] OP_FETCH = 5'd8;
  localparam logic [4:0] OP_STORE = 5'd9;
  localparam logic [4:0] OP_JMP   = 5'd11;
  localparam logic [4:0] OP_JZ    = 5'd12;
  localparam logic [4:0] OP_JNZ   = 5'd13;
  localparam logic [4:0] OP_ADD   = 5'd14;
  localparam logic [4:0] OP_SUB   = 5'd15;
  localparam logic [4:0] OP_MUL   = 5'd16;
  localparam logic [4:0] OP_DIV   = 5'd17;
  localparam logic [4:0] OP_MOD   = 5'd18;
  localparam logic [4:0] OP_AND   = 5'd19;
  localparam logic [4:0] OP_OR    = 5'd20;
  localparam logic [4:0] OP_NOT   = 5'd21;
  localparam logic [4:0] OP_EQ    = 5'd22;
  localparam logic [4:0] OP_NEQ   = 5'd23;
  localparam logic [4:0] OP_LT    = 5'd24;
  localparam logic [4:0] OP_GT    = 5'd25;
  localparam logic [4:0] OP_LE    = 5'd26;
  localparam logic [4:0] OP_GE    = 5'd27;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_UNDER = 3'd1;
  localparam status_t ST_OVER  = 3'd2;
  localparam status_t ST_DIVZ  = 3'd3;
  localparam status_t ST_UNSET = 3'd4;
  localparam status_t ST_BADOP = 3'd5;

  localparam logic [2:0] REG_PROGRAM_LENGTH = 3'd0;
  localparam int PLEN_W = 13;
endpackage

[rtl/smx_in_if.sv]
// Instruction channel: valid, ready and one instruction.
`timescale 1ns / 1ps
interface smx_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         func;
  logic signed [31:0] immediate;
  logic [7:0]         var_index;
  modport source (output valid, func, immediate, var_index, input ready);
  modport sink (input valid, func, immediate, var_index, output ready);
endinterface

[rtl/smx_out_if.sv]
// Result channel: valid, ready and one execution report.
`timescale 1ns / 1ps
interface smx_out_if #(
  parameter int IPW = 13,
  parameter int CW  = 7
);
  logic               valid;
  logic               ready;
  logic [IPW-1:0]     next_ip;
  logic signed [31:0] top_value;
  logic [CW-1:0]      stack_level;
  logic [2:0]         status;
  logic               halted;
  modport source (output valid, next_ip, top_value, stack_level, status, halted, input ready);
  modport sink (input valid, next_ip, top_value, stack_level, status, halted, output ready);
endinterface

[rtl/smx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/stack_machine_execute_core.sv]
// Top level of the stack machine execute core.
//   channel  | dir | transaction
//   in_ch    | in  | one instruction: func, immediate, var_index
//   out_ch   | out | one report: next_ip, top_value, stack_level, status, halted
//   APB      | in  | program_length at byte address 0
// For most instructions the accept cycle reads the stack and variable RAMs, and the
// EXEC state executes and commits. Divide and modulo use the one-bit-per-cycle
// divider (accept, setup, 32 steps, commit). A new instruction is accepted only in
// idle, while the previous report may still wait in the output register; a report
// that is not taken holds the commit. Reset is synchronous; it clears the state,
// pointer, depth, stop flag, program length, report valid and variable valid bits.
`timescale 1ns / 1ps
`include "stack_machine_execute_core_assert.svh"
module stack_machine_execute_core #(
  parameter int STACK_DEPTH   = 64,
  parameter int VAR_COUNT     = 256,
  parameter int PROGRAM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  smx_in_if.sink      in_ch,
  smx_out_if.source   out_ch
);
  import smx_pkg::*;

  localparam int IPW = $clog2(PROGRAM_DEPTH + 1);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int VIW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [2:0]         state;
  logic [PLEN_W-1:0]  program_length;
  logic [IPW-1:0]     ip;
  logic [CW-1:0]      count;
  logic [31:0]        top_q;
  logic               stopped;
  logic [VAR_COUNT-1:0] var_valid;
  logic [4:0]         func_q;
  logic [31:0]        imm_q;
  logic [31:0]        vi_q;
  logic [31:0]        second;
  logic [31:0]        var_rdata;
  logic [31:0]        dq;
  logic [31:0]        drem;
  logic [31:0]        dmag;
  logic [4:0]         dcnt;
  logic               neg_q;
  logic               neg_r;
  logic               out_valid;

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_PROGRAM_LENGTH[0]) begin
      prdata = 32'(program_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_PROGRAM_LENGTH[0]) begin
      program_length <= pwdata[PLEN_W-1:0];
    end
  end

  // Effective program length and jump target.
  logic [31:0]    plen32;
  logic [IPW-1:0] plen;
  logic [IPW-1:0] jdest;
  logic           pre_halt;
  assign plen32 = (32'(program_length) > PROGRAM_DEPTH) ? 32'(PROGRAM_DEPTH)
                                                        : 32'(program_length);
  assign plen   = plen32[IPW-1:0];
  assign jdest  = (imm_q[31] || imm_q >= plen32) ? plen : imm_q[IPW-1:0];
  assign pre_halt = stopped || ip >= plen;

  // Operands and the shared arithmetic, logic and compare unit.
  logic signed [31:0] sa;
  logic signed [31:0] sb;
  logic [31:0]        prod;
  logic [31:0]        alu_r;
  logic [31:0]        div_r;
  logic [31:0]        r;
  assign sa   = signed'(top_q);
  assign sb   = signed'(second);
  assign prod = top_q * second;
  assign div_r = (func_q == OP_DIV) ? (neg_q ? (32'd0 - dq) : dq)
                                    : (neg_r ? (32'd0 - drem) : drem);

  always_comb begin
    case (func_q)
      OP_ADD: alu_r = top_q + second;
      OP_SUB: alu_r = top_q - second;
      OP_MUL: alu_r = prod;
      OP_AND: alu_r = 32'((top_q != 0) && (second != 0));
      OP_OR:  alu_r = 32'((top_q != 0) || (second != 0));
      OP_EQ:  alu_r = 32'(sa == sb);
      OP_NEQ: alu_r = 32'(sa != sb);
      OP_LT:  alu_r = 32'(sa < sb);
      OP_GT:  alu_r = 32'(sa > sb);
      OP_LE:  alu_r = 32'(sa <= sb);
      OP_GE:  alu_r = 32'(sa >= sb);
      default: alu_r = 32'd0;
    endcase
  end
  assign r = (state == S_FIN) ? div_r : alu_r;

  // Instruction decode: status, next pointer, stack and variable updates.
  status_t        st;
  logic [IPW-1:0] nxt;
  logic [CW-1:0]  cnt_n;
  logic [31:0]    top_n;
  logic           swe;
  logic [SAW-1:0] swaddr;
  logic           vwe;
  logic           need_div;
  logic           var_in_range;
  assign var_in_range = vi_q < VAR_COUNT;

  always_comb begin
    st       = ST_OK;
    nxt      = ip + IPW'(1);
    cnt_n    = count;
    top_n    = top_q;
    swe      = 1'b0;
    swaddr   = count[SAW-1:0];
    vwe      = 1'b0;
    need_div = 1'b0;
    case (func_q)
      OP_PUSH, OP_FETCH: begin
        if (32'(count) >= STACK_DEPTH) begin
          st = ST_OVER;
        end else if (func_q == OP_FETCH && (!var_in_range || !var_valid[vi_q[VIW-1:0]])) begin
          st = ST_UNSET;
        end else begin
          top_n = (func_q == OP_PUSH) ? imm_q : var_rdata;
          cnt_n = count + CW'(1);
          swe   = 1'b1;
        end
      end
      OP_POP, OP_STORE, OP_NOT: begin
        if (count == '0) begin
          st = ST_UNDER;
        end else if (func_q == OP_NOT) begin
          top_n  = 32'(top_q == 32'd0);
          swe    = 1'b1;
          swaddr = SAW'(count - CW'(1));
        end else begin
          vwe   = (func_q == OP_STORE) && var_in_range;
          cnt_n = count - CW'(1);
          top_n = second;
        end
      end
      OP_JMP: begin
        nxt = jdest;
      end
      OP_JZ, OP_JNZ: begin
        if (count == '0) begin
          st = ST_UNDER;
        end else if ((top_q == 32'd0) == (func_q == OP_JZ)) begin
          nxt   = jdest;
          cnt_n = count - CW'(1);
          top_n = second;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
      OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_LE, OP_GE: begin
        if (count < CW'(2)) begin
          st = ST_UNDER;
        end else if ((func_q == OP_DIV || func_q == OP_MOD) && second == 32'd0) begin
          st = ST_DIVZ;
        end else begin
          need_div = (func_q == OP_DIV || func_q == OP_MOD);
          cnt_n    = count - CW'(1);
          top_n    = r;
          swe      = 1'b1;
          swaddr   = SAW'(count - CW'(2));
        end
      end
      default: begin
        st = ST_BADOP;
      end
    endcase
  end

  // Commit point: the output register must be free.
  logic out_free;
  logic commit;
  logic apply;
  logic in_acc;
  assign out_free = !out_valid || out_ch.ready;
  assign commit   = out_free && ((state == S_EXEC && (pre_halt || !need_div)) ||
                                 state == S_FIN);
  assign apply    = commit && !pre_halt && st == ST_OK;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  // Operand stack and variable store RAMs.
  logic [CW-1:0] rd_cnt;
  assign rd_cnt = count - CW'(2);

  smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (apply && swe),
    .waddr (swaddr),
    .wdata (top_n),
    .re    (in_acc),
    .raddr (rd_cnt[SAW-1:0]),
    .rdata (second)
  );

  logic [31:0] vi_in;
  assign vi_in = 32'(in_ch.var_index);

  smx_ram #(.WIDTH(32), .DEPTH(VAR_COUNT)) u_var_ram (
    .clk   (clk),
    .we    (apply && vwe),
    .waddr (vi_q[VIW-1:0]),
    .wdata (top_q),
    .re    (in_acc),
    .raddr (vi_in[VIW-1:0]),
    .rdata (var_rdata)
  );

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ip        <= '0;
      count     <= '0;
      stopped   <= 1'b0;
      var_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
          end else if (!pre_halt && need_div) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == 5'd31) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (apply) begin
        ip    <= nxt;
        count <= cnt_n;
        if (vwe) begin
          var_valid[vi_q[VIW-1:0]] <= 1'b1;
        end
      end
      if (commit && !pre_halt && st != ST_OK) begin
        stopped <= 1'b1;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Instruction capture, top-of-stack cache and the report register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_q <= in_ch.func;
      imm_q  <= in_ch.immediate;
      vi_q   <= vi_in;
    end
    if (apply) begin
      top_q <= top_n;
    end
    if (commit) begin
      out_ch.next_ip     <= apply ? nxt : ip;
      out_ch.top_value   <= apply ? ((cnt_n == '0) ? 32'sd0 : signed'(top_n))
                                  : ((count == '0) ? 32'sd0 : signed'(top_q));
      out_ch.stack_level <= apply ? cnt_n : count;
      out_ch.status      <= pre_halt ? ST_OK : st;
      out_ch.halted      <= apply ? (nxt >= plen) : 1'b1;
    end
  end
  assign out_ch.valid = out_valid;

  // Restoring divider on magnitudes, one quotient bit per cycle.
  logic [32:0] rem_sh;
  assign rem_sh = {drem, dq[31]};

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      dq    <= top_q[31] ? (32'd0 - top_q) : top_q;
      dmag  <= second[31] ? (32'd0 - second) : second;
      drem  <= '0;
      dcnt  <= '0;
      neg_q <= top_q[31] ^ second[31];
      neg_r <= top_q[31];
    end else if (state == S_DIV) begin
      dcnt <= dcnt + 5'd1;
      if (rem_sh >= {1'b0, dmag}) begin
        drem <= rem_sh[31:0] - dmag;
        dq   <= {dq[30:0], 1'b1};
      end else begin
        drem <= rem_sh[31:0];
        dq   <= {dq[30:0], 1'b0};
      end
    end
  end

  // Checks on the sequencer and the architectural state.
  `SMX_ASSERT_NOW(a_depth_bound, 1'b1, 32'(count) <= STACK_DEPTH)
  `SMX_ASSERT_NEXT(a_stopped_holds_ip, stopped, $stable(ip) && stopped)
  `SMX_ASSERT_NEXT(a_accept_to_exec, in_acc, state == S_EXEC)
  `SMX_ASSERT_NEXT(a_error_stops, commit && !pre_halt && st != ST_OK, stopped)
endmodule
